FILE: rtl/core/mvcc_row_version_manager_defines.svh
// assertion helpers for the row version manager
`ifndef MVCC_ROW_VERSION_MANAGER_DEFINES_SVH
`define MVCC_ROW_VERSION_MANAGER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MVCC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define MVCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/mvcc_pkg.sv
`default_nettype none
package mvcc_pkg;

    // fixed field widths
    localparam int STAMP_W           = 63;
    localparam int MODE_W            = 2;
    localparam int SLOT_W            = 3;
    localparam int HISTORY_SLOTS_DEF = 8;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COMMIT = 2'd2;
    localparam logic [MODE_W-1:0] MODE_ABORT  = 2'd3;

    // input word
    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [STAMP_W-1:0] txn_ts;
    } t_in_word;

    // result word
    typedef struct packed {
        logic              aborted;
        logic              from_history;
        logic [SLOT_W-1:0] slot_index;
    } t_out_word;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_scan;
        logic scan_last;
    } t_dp_status;

endpackage
`default_nettype wire

FILE: rtl/core/mvcc_ctrl.sv
`default_nettype none
module mvcc_ctrl
    import mvcc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire t_dp_status i_status,
    output t_ctrl_cmd       o_cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DECIDE = 2'd1;
    localparam logic [1:0] ST_SCAN   = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign busy = (r_state != ST_IDLE);

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (i_status.need_scan) begin
                    n_state = ST_SCAN;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            ST_SCAN: begin
                o_cmd.step = 1'b1;
                if (i_status.scan_last) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/mvcc_dp.sv
`default_nettype none
module mvcc_dp
    import mvcc_pkg::*;
#(
    parameter int HISTORY_SLOTS = HISTORY_SLOTS_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_in_word  i_cmd_word,
    input  wire t_ctrl_cmd i_cmd,
    output t_dp_status     o_status,
    output logic           o_done,
    output t_out_word      o_result
);

    localparam int IDXW = $clog2(HISTORY_SLOTS);
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(HISTORY_SLOTS - 1);

    // row version state
    logic [HISTORY_SLOTS-1:0] r_valid, n_valid;
    logic [HISTORY_SLOTS-1:0] r_resv, n_resv;
    logic [STAMP_W-1:0]       r_stamp [HISTORY_SLOTS];
    logic [STAMP_W-1:0]       r_lws, n_lws;
    logic                     r_lat_hist, n_lat_hist;
    logic [IDXW-1:0]          r_lat_slot, n_lat_slot;
    logic                     r_pend, n_pend;
    logic [IDXW-1:0]          r_pend_slot, n_pend_slot;
    logic [STAMP_W-1:0]       r_hrs, n_hrs;

    // current operation and scan state
    logic [MODE_W-1:0]  r_mode;
    logic [STAMP_W-1:0] r_ts;
    logic [IDXW-1:0]    r_idx;
    logic [STAMP_W-1:0] r_best;
    logic               r_found;
    logic [IDXW-1:0]    r_fslot;

    // result register
    logic      r_done;
    t_out_word r_res, n_res;

    logic                     read_new;
    logic                     late;
    logic [HISTORY_SLOTS-1:0] free_vec;
    logic                     has_free;
    logic [IDXW-1:0]          free_idx;
    logic [STAMP_W-1:0]       cur_stamp;
    logic                     cand;
    logic                     take;
    logic                     s_found;
    logic [IDXW-1:0]          s_slot;
    logic                     stamp_we;
    logic [IDXW-1:0]          stamp_waddr;
    logic [IDXW-1:0]          out_slot;
    logic [IDXW+SLOT_W-1:0]   out_slot_ext;

    // operation classification
    assign read_new = (r_ts > r_lws);
    assign late     = (r_ts < r_lws) || (r_ts < r_hrs) || r_pend;
    assign free_vec = ~(r_valid | r_resv);
    assign has_free = |free_vec;

    // lowest free slot
    always_comb begin
        free_idx = '0;
        for (int i = HISTORY_SLOTS - 1; i >= 0; i--) begin
            if (free_vec[i]) begin
                free_idx = IDXW'(i);
            end
        end
    end

    assign o_status.need_scan = ((r_mode == MODE_READ) && !read_new) ||
                                ((r_mode == MODE_WRITE) && !late && !has_free);
    assign o_status.scan_last = (r_idx == LAST_IDX);

    // one slot per scan step: history search for reads, oldest victim for writes
    assign cur_stamp = r_stamp[r_idx];
    always_comb begin
        if (r_mode == MODE_READ) begin
            cand = r_valid[r_idx] && (cur_stamp < r_ts) && (cur_stamp > r_best);
        end else begin
            cand = r_valid[r_idx] && !r_resv[r_idx] &&
                   !(r_lat_hist && (r_lat_slot == r_idx)) &&
                   (!r_found || (cur_stamp < r_best));
        end
    end
    assign take    = i_cmd.step && cand;
    assign s_found = r_found || take;
    assign s_slot  = take ? r_idx : r_fslot;

    // outcome of the operation
    always_comb begin
        n_valid     = r_valid;
        n_resv      = r_resv;
        n_lws       = r_lws;
        n_lat_hist  = r_lat_hist;
        n_lat_slot  = r_lat_slot;
        n_pend      = r_pend;
        n_pend_slot = r_pend_slot;
        n_hrs       = r_hrs;
        n_res       = '0;
        out_slot    = '0;
        stamp_we    = 1'b0;
        stamp_waddr = has_free ? free_idx : s_slot;
        if (i_cmd.finish) begin
            unique case (r_mode)
                MODE_READ: begin
                    if (read_new) begin
                        n_res.from_history = r_lat_hist;
                        out_slot           = r_lat_hist ? r_lat_slot : '0;
                        if (r_ts > r_hrs) begin
                            n_hrs = r_ts;
                        end
                    end else begin
                        n_res.from_history = s_found;
                        out_slot           = s_found ? s_slot : '0;
                    end
                end
                MODE_WRITE: begin
                    if (late || (!has_free && !s_found)) begin
                        n_res.aborted = 1'b1;
                    end else begin
                        stamp_we             = 1'b1;
                        n_valid[stamp_waddr] = 1'b0;
                        n_resv[stamp_waddr]  = 1'b1;
                        n_pend               = 1'b1;
                        n_pend_slot          = stamp_waddr;
                        out_slot             = stamp_waddr;
                    end
                end
                MODE_COMMIT: begin
                    if (r_pend) begin
                        n_valid[r_pend_slot] = 1'b1;
                        n_resv[r_pend_slot]  = 1'b0;
                        n_lws                = r_ts;
                        n_lat_hist           = 1'b1;
                        n_lat_slot           = r_pend_slot;
                        n_pend               = 1'b0;
                        out_slot             = r_pend_slot;
                    end
                end
                MODE_ABORT: begin
                    if (r_pend) begin
                        n_valid[r_pend_slot] = 1'b0;
                        n_resv[r_pend_slot]  = 1'b0;
                        n_pend               = 1'b0;
                        out_slot             = r_pend_slot;
                    end
                end
                default: begin
                    n_res = '0;
                end
            endcase
        end
        out_slot_ext     = {{SLOT_W{1'b0}}, out_slot};
        n_res.slot_index = out_slot_ext[SLOT_W-1:0];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_resv      <= '0;
            r_lws       <= '0;
            r_lat_hist  <= 1'b0;
            r_lat_slot  <= '0;
            r_pend      <= 1'b0;
            r_pend_slot <= '0;
            r_hrs       <= '0;
            r_done      <= 1'b0;
        end else begin
            r_valid     <= n_valid;
            r_resv      <= n_resv;
            r_lws       <= n_lws;
            r_lat_hist  <= n_lat_hist;
            r_lat_slot  <= n_lat_slot;
            r_pend      <= n_pend;
            r_pend_slot <= n_pend_slot;
            r_hrs       <= n_hrs;
            r_done      <= i_cmd.finish;
        end
    end

    // slot stamps, written on reservation
    always_ff @(posedge i_clk) begin
        if (stamp_we) begin
            r_stamp[stamp_waddr] <= r_ts;
        end
    end

    // operation capture and scan registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= i_cmd_word.mode;
            r_ts    <= i_cmd_word.txn_ts;
            r_idx   <= '0;
            r_best  <= '0;
            r_found <= 1'b0;
            r_fslot <= '0;
        end else if (i_cmd.step) begin
            r_idx <= r_idx + 1'b1;
            if (take) begin
                r_best  <= cur_stamp;
                r_found <= 1'b1;
                r_fslot <= r_idx;
            end
        end
        if (i_cmd.finish) begin
            r_res <= n_res;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule
`default_nettype wire

FILE: rtl/core/mvcc_row_version_manager.sv
// Row version manager: keeps the version history of one row under
// multiversion timestamp ordering.
// Command channel: present i_cmd (mode, txn_ts) with start high; the word is
// taken at a rising edge where start is high and busy is low.
// Result channel: o_result is valid for exactly one cycle while o_done is
// high; the receiver has no way to stall it and must take it then.
// Sequencing: commits, aborts, reads served the latest version and writes
// that find a free slot or are refused early pass from accept through the
// decide state to o_done. Reads of history and writes that must evict walk
// the slot stamps one slot per cycle through a single compare unit, in the
// scan state after the decide state. busy drops in the cycle o_done is high,
// so the next word may be taken at the edge that ends the result cycle.
// Reset (synchronous, active low): all slots free, latest version is the
// original row, no pending write, both timestamp marks zero.
`default_nettype none
`include "mvcc_row_version_manager_defines.svh"
module mvcc_row_version_manager
    import mvcc_pkg::*;
#(
    parameter int HISTORY_SLOTS = HISTORY_SLOTS_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire t_in_word i_cmd,
    output logic          o_done,
    output t_out_word     o_result
);

    t_ctrl_cmd  s_cmd;
    t_dp_status s_status;

    // sequencer
    mvcc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (s_status),
        .o_cmd    (s_cmd)
    );

    // version state and compare unit
    mvcc_dp #(
        .HISTORY_SLOTS (HISTORY_SLOTS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_word (i_cmd),
        .i_cmd      (s_cmd),
        .o_status   (s_status),
        .o_done     (o_done),
        .o_result   (o_result)
    );

    // checks
    `MVCC_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
    `MVCC_ASSERT_SAME(a_done_idle, o_done, !busy, "result strobe while still busy")
    `MVCC_ASSERT_NEXT(a_finish_done, s_cmd.finish, o_done, "finished operation gave no result")
    `MVCC_ASSERT_SAME(a_abort_clean, o_done && o_result.aborted,
        !o_result.from_history && (o_result.slot_index == '0), "refused write carries a slot")

endmodule
`default_nettype wire
